@@ design/gradient_noise_2d_defines.svh @@
// ----------------------------------------------------------------------------
// gradient_noise_2d_defines
// Assertion macros for the gradient noise block.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_DEFINES_SVH
`define GRADIENT_NOISE_2D_DEFINES_SVH
`ifndef ASSERT_OFF
`define GN_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gradient_noise_2d: same-cycle check failed");
`define GN_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gradient_noise_2d: next-cycle check failed");
`else
`define GN_ASSERT_IMPL(name, pre, post)
`define GN_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ design/gn2d_pkg.sv @@
// ----------------------------------------------------------------------------
// gn2d_pkg
// Constants, types and the gradient table function of the noise block.
// ----------------------------------------------------------------------------
package gn2d_pkg;

  typedef logic signed [33:0] corner_t;

  localparam logic [31:0] HASH_MX = 32'd374761393;
  localparam logic [31:0] HASH_MY = 32'd668265263;
  localparam logic [31:0] HASH_M1 = 32'd1274126177;
  localparam logic [31:0] HASH_M2 = 32'd2246822519;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic signed [17:0] SQRT2_Q16 = 18'sd92682;

  function automatic logic [15:0] to_q15(logic signed [63:0] acc);
    logic signed [63:0] a;
    logic signed [63:0] q;
    a = acc;
    if (a < 0) a = 0;
    if (a > $signed(ONE_Q30)) a = $signed(ONE_Q30);
    q = (a + 64'sd16384) >>> 15;
    if (q > 64'sd32767) q = 64'sd32767;
    return q[15:0];
  endfunction

  // {cos, sin} in Q1.15 for step r of a quadrant split into 2^(abits-2) steps
  function automatic logic [31:0] gn2d_trig(logic [63:0] r, int abits);
    logic [63:0] t;
    logic [63:0] tt;
    logic [63:0] term;
    logic signed [63:0] sacc;
    logic signed [63:0] cacc;
    t = (r * HALF_PI_Q30) >> (abits - 2);
    tt = (t * t) >> 30;
    term = t;
    sacc = $signed(t);
    term = ((term * tt) >> 30) / 6;   sacc = sacc - $signed(term);
    term = ((term * tt) >> 30) / 20;  sacc = sacc + $signed(term);
    term = ((term * tt) >> 30) / 42;  sacc = sacc - $signed(term);
    term = ((term * tt) >> 30) / 72;  sacc = sacc + $signed(term);
    term = ((term * tt) >> 30) / 110; sacc = sacc - $signed(term);
    term = ((term * tt) >> 30) / 156; sacc = sacc + $signed(term);
    term = ONE_Q30;
    cacc = $signed(ONE_Q30);
    term = ((term * tt) >> 30) / 2;   cacc = cacc - $signed(term);
    term = ((term * tt) >> 30) / 12;  cacc = cacc + $signed(term);
    term = ((term * tt) >> 30) / 30;  cacc = cacc - $signed(term);
    term = ((term * tt) >> 30) / 56;  cacc = cacc + $signed(term);
    term = ((term * tt) >> 30) / 90;  cacc = cacc - $signed(term);
    term = ((term * tt) >> 30) / 132; cacc = cacc + $signed(term);
    term = ((term * tt) >> 30) / 182; cacc = cacc - $signed(term);
    return {to_q15(cacc), to_q15(sacc)};
  endfunction

endpackage

@@ design/gn2d_hash.sv @@
// ----------------------------------------------------------------------------
// gn2d_hash
// Four-stage multiply-xorshift hash of one lattice corner and the seed.
// ----------------------------------------------------------------------------
module gn2d_hash (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] ix,
  input  logic [31:0] iy,
  input  logic [31:0] seed,
  output logic [31:0] hash
);
  import gn2d_pkg::*;

  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] sd;
  logic [31:0] h2;
  logic [31:0] h3;
  logic [31:0] h4;
  logic [31:0] sum;
  logic [31:0] x3;

  assign sum = px + py + sd;
  assign x3  = h3 ^ (h3 >> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      px <= ix * HASH_MX;
      py <= iy * HASH_MY;
      sd <= seed;
      h2 <= sum ^ (sum >> 13);
      h3 <= h2 * HASH_M1;
      h4 <= x3 * HASH_M2;
    end
  end

  assign hash = h4 ^ (h4 >> 13);
endmodule

@@ design/gn2d_fade.sv @@
// ----------------------------------------------------------------------------
// gn2d_fade
// Three-stage quintic fade 6t^5-15t^4+10t^3 of a Q0.16 fraction.
// ----------------------------------------------------------------------------
module gn2d_fade (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] t,
  output logic [16:0] fade
);
  logic [15:0] t1;
  logic [31:0] t2;
  logic [47:0] cube;
  logic signed [37:0] poly;
  logic signed [37:0] poly_next;
  logic [52:0] prod;

  assign poly_next = $signed({3'b000, t2, 3'b000}) - $signed({5'b0, t2, 1'b0})
                   - $signed(38'(t1) * 38'sd983040) + 38'sd42949672960;
  assign prod = 53'(cube[47:16]) * 53'(poly[36:16]) + 53'd2147483648;

  always_ff @(posedge clk) begin
    if (en) begin
      t1   <= t;
      t2   <= 32'(t) * 32'(t);
      cube <= 48'(t2) * 48'(t1);
      poly <= poly_next;
      fade <= prod[48:32];
    end
  end
endmodule

@@ design/gn2d_grad.sv @@
// ----------------------------------------------------------------------------
// gn2d_grad
// Gradient table lookup and gradient dot offset for one corner, two stages.
// ----------------------------------------------------------------------------
module gn2d_grad #(
  parameter int ANGLE_BITS = 10
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [31:0]             hash,
  input  logic signed [16:0]      dx,
  input  logic signed [16:0]      dy,
  output gn2d_pkg::corner_t       dot
);
  import gn2d_pkg::*;

  localparam int ENTRIES = 2 ** (ANGLE_BITS - 2);
  typedef logic [31:0] tab_t [ENTRIES];

  function automatic tab_t build_tab();
    tab_t tb;
    for (int i = 0; i < ENTRIES; i++) begin
      tb[i] = gn2d_trig(64'(i), ANGLE_BITS);
    end
    return tb;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [ANGLE_BITS-1:0] k;
  logic [1:0] quad;
  logic [31:0] cs;
  logic signed [15:0] c;
  logic signed [15:0] s;
  logic signed [15:0] gc_next;
  logic signed [15:0] gs_next;
  logic signed [15:0] gc;
  logic signed [15:0] gs;
  logic signed [16:0] dx1;
  logic signed [16:0] dy1;

  assign k    = hash[31 -: ANGLE_BITS];
  assign quad = k[ANGLE_BITS-1 -: 2];
  assign cs   = TAB[k[ANGLE_BITS-3:0]];
  assign c    = $signed(cs[31:16]);
  assign s    = $signed(cs[15:0]);

  always_comb begin
    case (quad)
      2'd0: begin gc_next = c;  gs_next = s;  end
      2'd1: begin gc_next = -s; gs_next = c;  end
      2'd2: begin gc_next = -c; gs_next = -s; end
      default: begin gc_next = s; gs_next = -c; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gc  <= gc_next;
      gs  <= gs_next;
      dx1 <= dx;
      dy1 <= dy;
      dot <= 34'(gc * dx1) + 34'(gs * dy1);
    end
  end
endmodule

@@ design/gradient_noise_2d.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise: four corner hashes, gradient dots, fade blend, scale.
// ----------------------------------------------------------------------------
// channel  signals                          direction
// input    in_valid in_ready x_coord y_coord seed   in
// output   out_valid out_ready noise_value          out
//
// Twelve-stage pipeline, one transfer in per cycle while the output is not stalled.
// The longest stages hold one 32-bit multiply (hash) or one blend multiply.
// A stall at the output freezes every stage; nothing is dropped or repeated.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "gradient_noise_2d_defines.svh"

module gradient_noise_2d #(
  parameter int ANGLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic [31:0]        seed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] noise_value
);
  import gn2d_pkg::*;

  localparam int DEPTH = 12;

  logic en;
  logic [DEPTH-1:0] vld;
  logic [31:0] ix0, iy0, ix1, iy1;
  logic [31:0] h00, h10, h01, h11;
  logic [15:0] fx_d [4];
  logic [15:0] fy_d [4];
  logic signed [16:0] dx0, dy0, dx1, dy1;
  logic [16:0] fu, fv;
  logic [16:0] u_d [3];
  logic [16:0] v_d [5];
  corner_t n00, n10, n01, n11;
  corner_t a0, a1;
  logic signed [52:0] px0, px1;
  logic signed [52:0] rx0, rx1;
  logic signed [35:0] nx0, nx1, nx0_d;
  logic signed [54:0] py;
  logic signed [54:0] ry;
  logic signed [35:0] n;
  logic signed [53:0] m;
  logic signed [53:0] mr;
  logic signed [21:0] res;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  assign ix0 = {{16{x_coord[31]}}, x_coord[31:16]};
  assign iy0 = {{16{y_coord[31]}}, y_coord[31:16]};
  assign ix1 = ix0 + 32'd1;
  assign iy1 = iy0 + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  gn2d_hash u_h00 (.clk, .en, .ix(ix0), .iy(iy0), .seed, .hash(h00));
  gn2d_hash u_h10 (.clk, .en, .ix(ix1), .iy(iy0), .seed, .hash(h10));
  gn2d_hash u_h01 (.clk, .en, .ix(ix0), .iy(iy1), .seed, .hash(h01));
  gn2d_hash u_h11 (.clk, .en, .ix(ix1), .iy(iy1), .seed, .hash(h11));

  gn2d_fade u_fx (.clk, .en, .t(x_coord[15:0]), .fade(fu));
  gn2d_fade u_fy (.clk, .en, .t(y_coord[15:0]), .fade(fv));

  always_ff @(posedge clk) begin
    if (en) begin
      fx_d[0] <= x_coord[15:0];
      fy_d[0] <= y_coord[15:0];
      for (int i = 1; i < 4; i++) begin
        fx_d[i] <= fx_d[i-1];
        fy_d[i] <= fy_d[i-1];
      end
      u_d[0] <= fu;
      for (int i = 1; i < 3; i++) u_d[i] <= u_d[i-1];
      v_d[0] <= fv;
      for (int i = 1; i < 5; i++) v_d[i] <= v_d[i-1];
    end
  end

  assign dx0 = $signed({1'b0, fx_d[3]});
  assign dy0 = $signed({1'b0, fy_d[3]});
  assign dx1 = dx0 - 17'sd65536;
  assign dy1 = dy0 - 17'sd65536;

  gn2d_grad #(.ANGLE_BITS(ANGLE_BITS)) u_g00 (.clk, .en, .hash(h00), .dx(dx0), .dy(dy0),
                                              .dot(n00));
  gn2d_grad #(.ANGLE_BITS(ANGLE_BITS)) u_g10 (.clk, .en, .hash(h10), .dx(dx1), .dy(dy0),
                                              .dot(n10));
  gn2d_grad #(.ANGLE_BITS(ANGLE_BITS)) u_g01 (.clk, .en, .hash(h01), .dx(dx0), .dy(dy1),
                                              .dot(n01));
  gn2d_grad #(.ANGLE_BITS(ANGLE_BITS)) u_g11 (.clk, .en, .hash(h11), .dx(dx1), .dy(dy1),
                                              .dot(n11));

  assign rx0 = px0 + 53'sd32768;
  assign rx1 = px1 + 53'sd32768;
  assign ry  = py + 55'sd32768;
  assign mr  = m + 54'sd2147483648;
  assign res = mr[53:32];

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= n00;
      a1  <= n01;
      px0 <= (53'(n10) - 53'(n00)) * 53'($signed({1'b0, u_d[2]}));
      px1 <= (53'(n11) - 53'(n01)) * 53'($signed({1'b0, u_d[2]}));
      nx0 <= 36'(a0) + 36'(rx0[52:16]);
      nx1 <= 36'(a1) + 36'(rx1[52:16]);
      nx0_d <= nx0;
      py  <= (55'(nx1) - 55'(nx0)) * 55'($signed({1'b0, v_d[4]}));
      n   <= nx0_d + 36'(ry[54:16]);
      m   <= 54'(n) * 54'(SQRT2_Q16);
      if (res > 22'sd32767) begin
        noise_value <= 16'sh7fff;
      end else if (res < -22'sd32768) begin
        noise_value <= -16'sh8000;
      end else begin
        noise_value <= res[15:0];
      end
    end
  end

  `GN_ASSERT_NEXT(a_enter, in_valid && in_ready, vld[0])
  `GN_ASSERT_NEXT(a_freeze, !in_ready, $stable(vld))
  `GN_ASSERT_IMPL(a_ready, out_valid && !out_ready, !in_ready)
endmodule

@@ bench/gradient_noise_2d_tb.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_2d_tb
// Drives points and seeds into the noise block with bursty input and a
// stalling output, predicts each sample with an independent fixed-point
// model, and checks the samples in order.
// ----------------------------------------------------------------------------
module gradient_noise_2d_tb;

  localparam int ANGLE_BITS   = 10;
  localparam int LATENCY      = 12;
  localparam int N_RANDOM     = 1930;
  localparam int IDLE_LIMIT   = 20000;

  function automatic logic signed [15:0] sat_q15(logic signed [63:0] acc);
    logic signed [63:0] q;
    if (acc < 0) acc = 0;
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    q = (acc + 64'sd16384) >>> 15;
    if (q > 64'sd32767) q = 64'sd32767;
    return q[15:0];
  endfunction

  // gradient {cos, sin} in Q1.15 from the top bits of a corner hash
  function automatic logic [31:0] grad_of_hash(logic [31:0] h);
    logic [31:0] k;
    logic [1:0] quad;
    logic [63:0] r, t, tt, term;
    logic signed [63:0] sacc, cacc;
    logic signed [15:0] c, s, gc, gs;
    k = h >> (32 - ANGLE_BITS);
    quad = k[ANGLE_BITS-1 -: 2];
    r = k & ((32'd1 << (ANGLE_BITS - 2)) - 1);
    t = (r * 64'd1686629713) >> (ANGLE_BITS - 2);
    tt = (t * t) >> 30;
    term = t;
    sacc = $signed(t);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * tt) >> 30) / ((2 * n) * (2 * n + 1));
      sacc = n[0] ? sacc - $signed(term) : sacc + $signed(term);
    end
    term = 64'd1 << 30;
    cacc = 64'sd1 << 30;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * tt) >> 30) / ((2 * n - 1) * (2 * n));
      cacc = n[0] ? cacc - $signed(term) : cacc + $signed(term);
    end
    c = sat_q15(cacc);
    s = sat_q15(sacc);
    case (quad)
      2'd0: begin gc = c;  gs = s;  end
      2'd1: begin gc = -s; gs = c;  end
      2'd2: begin gc = -c; gs = -s; end
      default: begin gc = s; gs = -c; end
    endcase
    return {gc, gs};
  endfunction

  function automatic logic [31:0] lattice_hash(logic [31:0] ix, iy, sd);
    logic [31:0] h;
    h = ix * 32'd374761393 + iy * 32'd668265263 + sd;
    h ^= h >> 13;
    h = h * 32'd1274126177;
    h ^= h >> 16;
    h = h * 32'd2246822519;
    h ^= h >> 13;
    return h;
  endfunction

  // floor((v + 2^(s-1)) / 2^s)
  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [63:0] corner_dot(logic [31:0] ix, iy, sd,
                                                    logic signed [63:0] dx, dy);
    logic [31:0] g;
    g = grad_of_hash(lattice_hash(ix, iy, sd));
    return $signed(g[31:16]) * dx + $signed(g[15:0]) * dy;
  endfunction

  function automatic logic signed [63:0] quintic(logic [15:0] f);
    logic [63:0] tv, cube, prod;
    logic signed [63:0] p;
    tv = f;
    p = 6 * $signed(tv * tv) - 15 * 65536 * $signed(tv) + (64'sd10 <<< 32);
    cube = (tv * tv * tv) >> 16;
    prod = cube * (p >> 16);
    return $signed((prod + (64'd1 << 31)) >> 32);
  endfunction

  function automatic logic signed [15:0] noise_of(logic [31:0] x, y, sd);
    logic [31:0] ix0, iy0, ix1, iy1;
    logic signed [63:0] dx0, dy0, dx1, dy1, n00, n10, n01, n11, u, v, a, b, n, res;
    ix0 = {{16{x[31]}}, x[31:16]};
    iy0 = {{16{y[31]}}, y[31:16]};
    ix1 = ix0 + 1;
    iy1 = iy0 + 1;
    dx0 = x[15:0];
    dy0 = y[15:0];
    dx1 = dx0 - 65536;
    dy1 = dy0 - 65536;
    n00 = corner_dot(ix0, iy0, sd, dx0, dy0);
    n10 = corner_dot(ix1, iy0, sd, dx1, dy0);
    n01 = corner_dot(ix0, iy1, sd, dx0, dy1);
    n11 = corner_dot(ix1, iy1, sd, dx1, dy1);
    u = quintic(x[15:0]);
    v = quintic(y[15:0]);
    a = n00 + rnd_shift(u * (n10 - n00), 16);
    b = n01 + rnd_shift(u * (n11 - n01), 16);
    n = a + rnd_shift(v * (b - a), 16);
    res = rnd_shift(n * 92682, 32);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  class noise_scoreboard;
    logic signed [15:0] pending[$];
    int errors;

    function void note_point(logic [31:0] x, y, sd);
      pending.push_back(noise_of(x, y, sd));
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
        $error("noise_value: unexpected transfer, actual %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("noise_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] x_coord, y_coord;
  logic [31:0] seed;
  logic signed [15:0] noise_value;
  noise_scoreboard sb;
  int idle_cycles;
  bit timed_out;

  gradient_noise_2d #(.ANGLE_BITS(ANGLE_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_coord(x_coord), .y_coord(y_coord), .seed(seed),
    .out_valid(out_valid), .out_ready(out_ready),
    .noise_value(noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_point(x_coord, y_coord, seed);
    if (!rst && out_valid && out_ready) sb.check_sample(noise_value);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        sb.pending.size() == 0 && !in_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      timed_out = 1'b1;
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern: runs of ready and stall of random length
  initial begin
    int run;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      run = $urandom_range(1, 30);
      out_ready <= ($urandom_range(0, 3) != 0);
      repeat (run) @(posedge clk);
    end
  end

  int burst_left;

  task automatic send_point(logic [31:0] x, y, sd);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    seed <= sd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      2: return {16'($urandom_range(32760, 32775)), 16'($urandom)};
      3: return {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
      default: return {16'($urandom_range(0, 15)), 16'($urandom)};
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[8];
    sb = new();
    timed_out = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    x_coord = '0;
    y_coord = '0;
    seed = '0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    edge_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h7FFF_0000, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_0001};
    for (int i = 0; i < 8; i++)
      send_point(edge_vals[i], edge_vals[(i * 3 + 1) % 8], i[0] ? 32'hFFFF_FFFF : 32'h0);
    // zero angle and saturation hunting
    for (int i = 0; i < 12; i++)
      send_point({16'h7FFF, 16'($urandom)}, rand_coord(), $urandom);
    for (int i = 0; i < N_RANDOM; i++)
      send_point(rand_coord(), rand_coord(), $urandom);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.errors == 0 && !timed_out)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/gn2d_pkg.sv
design/gn2d_hash.sv
design/gn2d_fade.sv
design/gn2d_grad.sv
design/gradient_noise_2d.sv
bench/gradient_noise_2d_tb.sv
